// ===== design/pmul_pkg.sv =====
// ----------------------------------------------------------------------------
// pmul_pkg
// Shared types and constants for the polynomial multiply core.
// ----------------------------------------------------------------------------
`default_nettype none

package pmul_pkg;

  localparam int MAX_DEGREE_DEF = 31;
  localparam int COEF_WIDTH_DEF = 16;

  localparam int OPCODE_W = 2;
  localparam int INDEX_W  = 5;
  localparam int VALUE_W  = 16;
  localparam int DEGREE_W = 5;
  localparam int POWER_W  = 6;
  localparam int PROD_W   = 37;
  localparam int APB_AW   = 3;
  localparam int APB_DW   = 32;

  localparam logic [OPCODE_W-1:0] OP_LOAD_P   = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_LOAD_Q   = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_MULTIPLY = 2'd2;

  localparam logic REG_DEGREE_P = 1'b0;
  localparam logic REG_DEGREE_Q = 1'b1;

  typedef struct packed {
    logic valid;
    logic first;
  } mac_ctl_t;

endpackage

`default_nettype wire

// ===== design/pmul_ram.sv =====
// ----------------------------------------------------------------------------
// pmul_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module pmul_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== design/pmul_mac.sv =====
// ----------------------------------------------------------------------------
// pmul_mac
// Multiply-accumulate pipeline around the product-sum memory.
// ----------------------------------------------------------------------------
`default_nettype none

module pmul_mac
  import pmul_pkg::*;
#(
  parameter int MAX_DEGREE = MAX_DEGREE_DEF,
  parameter int COEF_WIDTH = COEF_WIDTH_DEF,
  localparam int AW    = $clog2(MAX_DEGREE + 1),
  localparam int NSUM  = 2 * MAX_DEGREE + 1,
  localparam int KW    = $clog2(NSUM),
  localparam int SW    = 2 * COEF_WIDTH + AW
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire mac_ctl_t              ctl,
  input  wire logic [KW-1:0]         k,
  input  wire logic [COEF_WIDTH-1:0] p_coef,
  input  wire logic [COEF_WIDTH-1:0] q_coef,
  input  wire logic [KW-1:0]         emit_addr,
  output logic      [SW-1:0]         sum_rdata,
  output logic                       busy
);

  logic                         s1_valid;
  logic                         s1_first;
  logic [KW-1:0]                s1_k;
  logic                         s2_valid;
  logic                         s2_first;
  logic [KW-1:0]                s2_k;
  logic signed [2*COEF_WIDTH-1:0] s2_prod;
  logic                         last_valid;
  logic [KW-1:0]                last_k;
  logic signed [SW-1:0]         last_wdata;
  logic signed [SW-1:0]         prod_ext;
  logic signed [SW-1:0]         base;
  logic signed [SW-1:0]         wdata;
  logic [KW-1:0]                raddr;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      s2_valid   <= 1'b0;
      last_valid <= 1'b0;
    end else begin
      s1_valid   <= ctl.valid;
      s2_valid   <= s1_valid;
      last_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_first   <= ctl.first;
    s1_k       <= k;
    s2_first   <= s1_first;
    s2_k       <= s1_k;
    s2_prod    <= signed'(p_coef) * signed'(q_coef);
    last_k     <= s2_k;
    last_wdata <= wdata;
  end

  // back-to-back hit on the same sum: take the value just written
  assign prod_ext = SW'(s2_prod);
  assign base     = (last_valid && (last_k == s2_k)) ? last_wdata : signed'(sum_rdata);
  assign wdata    = s2_first ? prod_ext : base + prod_ext;
  assign raddr    = s1_valid ? s1_k : emit_addr;
  assign busy     = s1_valid || s2_valid;

  pmul_ram #(
    .WIDTH (SW),
    .DEPTH (NSUM)
  ) u_sum_ram (
    .clk   (clk),
    .we    (s2_valid),
    .waddr (s2_k),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (sum_rdata)
  );

endmodule

`default_nettype wire

// ===== design/polynomial_multiply_core.sv =====
// ----------------------------------------------------------------------------
// polynomial_multiply_core
// Integer polynomial product by direct convolution over coefficient memories.
// ----------------------------------------------------------------------------
//  channel | signals                                   | carries
//  in      | in_valid/in_ready                         | opcode, coef_index, coef_value
//  out     | out_valid/out_ready                       | power, product_coef, last
//  cfg     | psel/penable/pwrite/paddr/pwdata/prdata   | degree_p, degree_q
//
//  Load: the value goes into the P or Q RAM. Multiply: a MAC pass over every
//  (i, j) pair through the single read port of each coefficient RAM, a pipeline
//  drain, then each product coefficient through the sum RAM read port.
//  No clearing pass: the first touch of each sum writes instead of adding.
//  in_ready is low from a multiply until its last coefficient is registered.
//  Reset is synchronous and clears control state and degree registers.
// ----------------------------------------------------------------------------
`default_nettype none

module polynomial_multiply_core
  import pmul_pkg::*;
#(
  parameter int MAX_DEGREE = MAX_DEGREE_DEF,
  parameter int COEF_WIDTH = COEF_WIDTH_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [OPCODE_W-1:0]        opcode,
  input  wire logic [INDEX_W-1:0]         coef_index,
  input  wire logic signed [VALUE_W-1:0]  coef_value,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [POWER_W-1:0]              power,
  output logic signed [PROD_W-1:0]        product_coef,
  output logic                            last,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [APB_AW-1:0]          paddr,
  input  wire logic [APB_DW-1:0]          pwdata,
  output logic [APB_DW-1:0]               prdata,
  output logic                            pready
);

  localparam int AW   = $clog2(MAX_DEGREE + 1);
  localparam int NSUM = 2 * MAX_DEGREE + 1;
  localparam int KW   = $clog2(NSUM);
  localparam int SW   = 2 * COEF_WIDTH + AW;

  typedef enum logic [4:0] {
    ST_IDLE    = 5'b00001,
    ST_MAC     = 5'b00010,
    ST_DRAIN   = 5'b00100,
    ST_EMIT_RD = 5'b01000,
    ST_EMIT_LD = 5'b10000
  } state_t;

  state_t                  state;
  state_t                  state_next;
  logic [DEGREE_W-1:0]     degree_p;
  logic [DEGREE_W-1:0]     degree_q;
  logic [AW-1:0]           dp;
  logic [AW-1:0]           dq;
  logic [AW-1:0]           i_cnt;
  logic [AW-1:0]           j_cnt;
  logic [KW-1:0]           emit_k;
  logic [KW-1:0]           total_k;
  logic                    in_xfer;
  logic                    out_xfer;
  logic                    idx_ok;
  logic [COEF_WIDTH-1:0]   load_val;
  logic [COEF_WIDTH-1:0]   p_coef;
  logic [COEF_WIDTH-1:0]   q_coef;
  logic [SW-1:0]           sum_rdata;
  logic                    mac_busy;
  mac_ctl_t                mac_ctl;
  logic [KW-1:0]           mac_k;
  logic                    mac_row_end;
  logic                    mac_done;
  logic                    emit_go;

  // configuration
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      degree_p <= '0;
      degree_q <= '0;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        REG_DEGREE_P: degree_p <= pwdata[DEGREE_W-1:0];
        REG_DEGREE_Q: degree_q <= pwdata[DEGREE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_DEGREE_P: prdata = APB_DW'(degree_p);
      REG_DEGREE_Q: prdata = APB_DW'(degree_q);
      default:      prdata = '0;
    endcase
  end

  assign dp      = (degree_p > DEGREE_W'(MAX_DEGREE)) ? AW'(MAX_DEGREE) : AW'(degree_p);
  assign dq      = (degree_q > DEGREE_W'(MAX_DEGREE)) ? AW'(MAX_DEGREE) : AW'(degree_q);
  assign total_k = KW'(dp) + KW'(dq);

  // input side
  assign in_ready = (state == ST_IDLE) && !rst;
  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;
  assign idx_ok   = (coef_index <= INDEX_W'(MAX_DEGREE));
  assign load_val = COEF_WIDTH'(coef_value);

  pmul_ram #(
    .WIDTH (COEF_WIDTH),
    .DEPTH (MAX_DEGREE + 1)
  ) u_p_ram (
    .clk   (clk),
    .we    (in_xfer && idx_ok && (opcode == OP_LOAD_P)),
    .waddr (coef_index[AW-1:0]),
    .wdata (load_val),
    .raddr (i_cnt),
    .rdata (p_coef)
  );

  pmul_ram #(
    .WIDTH (COEF_WIDTH),
    .DEPTH (MAX_DEGREE + 1)
  ) u_q_ram (
    .clk   (clk),
    .we    (in_xfer && idx_ok && (opcode == OP_LOAD_Q)),
    .waddr (coef_index[AW-1:0]),
    .wdata (load_val),
    .raddr (j_cnt),
    .rdata (q_coef)
  );

  // MAC issue
  assign mac_ctl.valid = (state == ST_MAC);
  assign mac_ctl.first = (i_cnt == '0) || (j_cnt == dq);
  assign mac_k         = KW'(i_cnt) + KW'(j_cnt);
  assign mac_row_end   = (j_cnt == dq);
  assign mac_done      = mac_row_end && (i_cnt == dp);
  assign emit_go       = !out_valid || out_ready;

  pmul_mac #(
    .MAX_DEGREE (MAX_DEGREE),
    .COEF_WIDTH (COEF_WIDTH)
  ) u_mac (
    .clk       (clk),
    .rst       (rst),
    .ctl       (mac_ctl),
    .k         (mac_k),
    .p_coef    (p_coef),
    .q_coef    (q_coef),
    .emit_addr (emit_k),
    .sum_rdata (sum_rdata),
    .busy      (mac_busy)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_xfer && (opcode == OP_MULTIPLY)) begin
          state_next = ST_MAC;
        end
      end
      ST_MAC: begin
        if (mac_done) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!mac_busy) begin
          state_next = ST_EMIT_RD;
        end
      end
      ST_EMIT_RD: begin
        if (emit_go) begin
          state_next = ST_EMIT_LD;
        end
      end
      ST_EMIT_LD: begin
        state_next = (emit_k == total_k) ? ST_IDLE : ST_EMIT_RD;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      i_cnt     <= '0;
      j_cnt     <= '0;
      emit_k    <= '0;
    end else begin
      state <= state_next;
      if (state == ST_EMIT_LD) begin
        out_valid <= 1'b1;
      end else if (out_xfer) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          i_cnt  <= '0;
          j_cnt  <= '0;
          emit_k <= '0;
        end
        ST_MAC: begin
          if (mac_row_end) begin
            j_cnt <= '0;
            if (!mac_done) begin
              i_cnt <= i_cnt + AW'(1);
            end
          end else begin
            j_cnt <= j_cnt + AW'(1);
          end
        end
        ST_EMIT_LD: begin
          emit_k <= emit_k + KW'(1);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EMIT_LD) begin
      power        <= POWER_W'(emit_k);
      product_coef <= PROD_W'(signed'(sum_rdata));
      last         <= (emit_k == total_k);
    end
  end

endmodule

`default_nettype wire

// ===== sim/polynomial_multiply_core_tb.sv =====
// ----------------------------------------------------------------------------
// polynomial_multiply_core_tb
// Drives coefficient loads and multiply commands into the core, writes the
// degree registers over APB between phases and checks every emitted product
// coefficient against a convolution computed here from the loaded values.
// ----------------------------------------------------------------------------
module polynomial_multiply_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pmul_pkg::*;

  localparam logic [OPCODE_W-1:0] OP_RESERVED = 2'd3;
  localparam int ITEM_TARGET = 430;
  localparam int HOLD_CYCLES = 400;

  typedef struct {
    logic [POWER_W-1:0]       pwr;
    logic signed [PROD_W-1:0] coef;
    logic                     is_last;
  } prod_term_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic [OPCODE_W-1:0]       opcode = '0;
  logic [INDEX_W-1:0]        coef_index = '0;
  logic signed [VALUE_W-1:0] coef_value = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [POWER_W-1:0]        power;
  logic signed [PROD_W-1:0]  product_coef;
  logic                      last;
  logic                      psel = 1'b0;
  logic                      penable = 1'b0;
  logic                      pwrite = 1'b0;
  logic [APB_AW-1:0]         paddr = '0;
  logic [APB_DW-1:0]         pwdata = '0;
  logic [APB_DW-1:0]         prdata;
  logic                      pready;

  logic signed [VALUE_W-1:0] first_poly [0:31];
  logic signed [VALUE_W-1:0] second_poly [0:31];
  logic [31:0]               first_written = '0;
  logic [31:0]               second_written = '0;
  logic [DEGREE_W-1:0]       deg_first = '0;
  logic [DEGREE_W-1:0]       deg_second = '0;

  prod_term_t expected_terms [$];
  int mismatch_count = 0;
  int items_sent = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_tokens = 0;
  int hold_taken = 0;
  int hold_left = 0;

  polynomial_multiply_core dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .opcode       (opcode),
    .coef_index   (coef_index),
    .coef_value   (coef_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .power        (power),
    .product_coef (product_coef),
    .last         (last),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #5 clk = ~clk;

  task automatic report_error(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("ERROR @%0t: %s", $realtime, msg);
    end
  endtask

  // Updates coefficient memories on loads, queues the product on multiplies.
  task automatic predict_transfer(input logic [OPCODE_W-1:0] op,
                                  input logic [INDEX_W-1:0] idx,
                                  input logic signed [VALUE_W-1:0] val);
    longint sums [0:62];
    int total;
    prod_term_t term;
    case (op)
      OP_LOAD_P: begin
        first_poly[idx] = val;
        first_written[idx] = 1'b1;
      end
      OP_LOAD_Q: begin
        second_poly[idx] = val;
        second_written[idx] = 1'b1;
      end
      OP_MULTIPLY: begin
        foreach (sums[k]) sums[k] = 0;
        for (int i = 0; i <= int'(deg_first); i++) begin
          for (int j = 0; j <= int'(deg_second); j++) begin
            sums[i + j] += longint'(first_poly[i]) * longint'(second_poly[j]);
          end
        end
        total = int'(deg_first) + int'(deg_second) + 1;
        for (int k = 0; k < total; k++) begin
          term.pwr = POWER_W'(k);
          term.coef = PROD_W'(sums[k]);
          term.is_last = (k == total - 1);
          expected_terms.push_back(term);
        end
      end
      default: ;
    endcase
  endtask

  task automatic send_item(input logic [OPCODE_W-1:0] op, input logic [INDEX_W-1:0] idx,
                           input logic signed [VALUE_W-1:0] val);
    @(negedge clk);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    opcode <= op;
    coef_index <= idx;
    coef_value <= val;
    do @(posedge clk); while (!in_ready);
    predict_transfer(op, idx, val);
    if (op != OP_RESERVED) items_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_terms.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic cfg_access(input logic wr, input logic sel, input logic [APB_DW-1:0] wdata,
                            output logic [APB_DW-1:0] rdata);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {sel, 2'b00};
    pwdata <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_degrees();
    logic [APB_DW-1:0] rd;
    cfg_access(1'b0, REG_DEGREE_P, '0, rd);
    if (rd !== APB_DW'(deg_first)) begin
      report_error($sformatf("degree_p read exp %0d got %0d", deg_first, rd));
    end
    cfg_access(1'b0, REG_DEGREE_Q, '0, rd);
    if (rd !== APB_DW'(deg_second)) begin
      report_error($sformatf("degree_q read exp %0d got %0d", deg_second, rd));
    end
  endtask

  // Upper data bits are random; only the low degree bits are kept.
  task automatic set_degrees(input logic [DEGREE_W-1:0] dp, input logic [DEGREE_W-1:0] dq);
    logic [APB_DW-1:0] rd;
    cfg_access(1'b1, REG_DEGREE_P, {27'($urandom), dp}, rd);
    deg_first = dp;
    cfg_access(1'b1, REG_DEGREE_Q, {27'($urandom), dq}, rd);
    deg_second = dq;
    check_degrees();
  endtask

  function automatic logic signed [VALUE_W-1:0] rand_coef();
    case ($urandom_range(7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return '0;
      default: return VALUE_W'($urandom);
    endcase
  endfunction

  task automatic fill_missing();
    for (int i = 0; i <= int'(deg_first); i++) begin
      if (!first_written[i]) send_item(OP_LOAD_P, INDEX_W'(i), rand_coef());
    end
    for (int i = 0; i <= int'(deg_second); i++) begin
      if (!second_written[i]) send_item(OP_LOAD_Q, INDEX_W'(i), rand_coef());
    end
  endtask

  always @(posedge clk) begin : check_results
    prod_term_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_terms.size() == 0) begin
        report_error($sformatf("unexpected transfer power=%0d coef=%0d last=%0b",
                               power, product_coef, last));
      end else begin
        want = expected_terms.pop_front();
        if (power !== want.pwr || product_coef !== want.coef || last !== want.is_last) begin
          report_error($sformatf(
            "power exp %0d got %0d, coef exp %0d got %0d, last exp %0b got %0b",
            want.pwr, power, want.coef, product_coef, want.is_last, last));
        end
      end
    end
  end

  always @(negedge clk) begin
    if (hold_taken != hold_tokens) begin
      hold_taken = hold_tokens;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic test_directed();
    check_degrees();
    send_item(OP_LOAD_P, 5'd0, 16'h8000);
    send_item(OP_LOAD_Q, 5'd0, 16'h8000);
    send_item(OP_MULTIPLY, 5'd0, '0);
    send_item(OP_RESERVED, 5'd31, 16'h5A5A);
    send_item(OP_MULTIPLY, 5'd31, 16'hFFFF);
    send_item(OP_LOAD_P, 5'd0, 16'h7FFF);
    send_item(OP_LOAD_Q, 5'd0, 16'hFFFF);
    send_item(OP_MULTIPLY, 5'd7, 16'h1234);
    wait_drained();
    set_degrees(5'd2, 5'd1);
    send_item(OP_LOAD_P, 5'd0, 16'sd1);
    send_item(OP_LOAD_P, 5'd1, -16'sd2);
    send_item(OP_LOAD_P, 5'd2, 16'sd3);
    send_item(OP_LOAD_Q, 5'd0, 16'h7FFF);
    send_item(OP_LOAD_Q, 5'd1, 16'h8000);
    send_item(OP_MULTIPLY, 5'd0, '0);
    // beyond the configured degree: must not disturb the product
    send_item(OP_LOAD_P, 5'd31, 16'h4321);
    send_item(OP_LOAD_Q, 5'd30, 16'hBCDE);
    send_item(OP_MULTIPLY, 5'd0, '0);
  endtask

  task automatic test_degree_extremes();
    wait_drained();
    set_degrees(5'd31, 5'd31);
    for (int i = 0; i < 32; i++) begin
      send_item(OP_LOAD_P, INDEX_W'(i), 16'h8000);
      send_item(OP_LOAD_Q, INDEX_W'(i), 16'h8000);
    end
    send_item(OP_MULTIPLY, '0, '0);
    wait_drained();
    set_degrees(5'd31, 5'd0);
    for (int i = 0; i < 32; i++) begin
      send_item(OP_LOAD_P, INDEX_W'(i), 16'h7FFF);
    end
    send_item(OP_MULTIPLY, '0, '0);
    wait_drained();
    set_degrees(5'd0, 5'd31);
    send_item(OP_MULTIPLY, '0, '0);
  endtask

  // Output held off long enough that the core stops taking input.
  task automatic test_backpressure();
    wait_drained();
    set_degrees(5'd5, 5'd6);
    fill_missing();
    @(posedge clk);
    hold_tokens++;
    send_item(OP_MULTIPLY, '0, '0);
    repeat (8) send_item(OP_LOAD_P, INDEX_W'($urandom_range(5)), rand_coef());
    send_item(OP_MULTIPLY, '0, '0);
    repeat (4) send_item(OP_LOAD_Q, INDEX_W'($urandom_range(6)), rand_coef());
    send_item(OP_MULTIPLY, '0, '0);
  endtask

  task automatic test_random_sequences(input int target);
    logic [DEGREE_W-1:0] dp;
    logic [DEGREE_W-1:0] dq;
    int r;
    while (items_sent < target) begin
      wait_drained();
      dp = ($urandom_range(7) == 0) ? DEGREE_W'($urandom_range(31))
                                    : DEGREE_W'($urandom_range(7));
      dq = ($urandom_range(7) == 0) ? DEGREE_W'($urandom_range(31))
                                    : DEGREE_W'($urandom_range(7));
      set_degrees(dp, dq);
      repeat ($urandom_range(1, 4)) begin
        fill_missing();
        repeat ($urandom_range(0, 6)) begin
          r = $urandom_range(9);
          if (r == 0) begin
            send_item(OP_RESERVED, INDEX_W'($urandom), VALUE_W'($urandom));
          end else begin
            send_item(r[0] ? OP_LOAD_P : OP_LOAD_Q, INDEX_W'($urandom_range(31)), rand_coef());
          end
        end
        send_item(OP_MULTIPLY, INDEX_W'($urandom), VALUE_W'($urandom));
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    send_idle_pct = 27;
    recv_idle_pct = 76;
    test_directed();
    test_degree_extremes();
    send_idle_pct = 76;
    recv_idle_pct = 27;
    test_backpressure();
    test_random_sequences(280);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_sequences(ITEM_TARGET);
    wait_drained();
    if (mismatch_count == 0 && expected_terms.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #50ms;
    $display("Some tests failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
design/pmul_pkg.sv
design/pmul_ram.sv
design/pmul_mac.sv
design/polynomial_multiply_core.sv
sim/polynomial_multiply_core_tb.sv
